// ----- design/assert_macros.svh -----
// Assertion helpers for the design files.
// Each macro expects a clock named clk and an active-low reset named arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Checks that a consequent holds in the same cycle as its antecedent.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ----- design/sv39_ptw_pkg.sv -----
//------------------------------------------------------------------------------
// Sv39 page table walker package
// Shared constants, codes and helper functions of the walker.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

package sv39_ptw_pkg;

	localparam int POOL_PAGES_DEF    = 64;
	localparam int VA_LIMIT_BITS_DEF = 38;
	localparam int ENTRIES_PER_TABLE = 512;
	localparam int IDX_BITS          = 9;
	localparam int PAGE_SHIFT        = 12;
	localparam int PPN_BITS          = 44;
	localparam int PAGES_BITS        = 27;

	localparam logic [PPN_BITS-1:0] POOL_BASE_RESET = 44'd524288;
	localparam logic [3:0]          REG_POOL_BASE   = 4'd0;

	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_RANGE  = 3'd1,
		ST_ALIGN  = 3'd2,
		ST_ZERO   = 3'd3,
		ST_REMAP  = 3'd4,
		ST_NOPAGE = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_START,
		S_EVAL,
		S_ZERO,
		S_LINK,
		S_DONE
	} walk_state_t;

	localparam logic KIND_LOOKUP = 1'b0;
	localparam logic KIND_MAP    = 1'b1;

	// Table index of a virtual address at one level of the walk.
	function automatic logic [IDX_BITS-1:0] vpn_of(input logic [63:0] va,
		input logic [1:0] lvl);
		logic [IDX_BITS-1:0] r;
		case (lvl)
			2'd2:    r = va[38:30];
			2'd1:    r = va[29:21];
			default: r = va[20:12];
		endcase
		return r;
	endfunction

	// Table entry with a page number and flag bits.
	function automatic logic [63:0] make_entry(input logic [PPN_BITS-1:0] ppn,
		input logic [9:0] flags);
		return {10'd0, ppn, flags};
	endfunction

endpackage

// ----- design/sv39_page_table_walk_and_map_unit.sv -----
//------------------------------------------------------------------------------
// Sv39 page table walk and map unit
// Looks up and maps pages in a three-level table held in an internal pool.
//------------------------------------------------------------------------------
// A lookup reads table entries level by level from the top down, then returns its
// result; a map walks each page of its range in turn and writes its leaf.
// Each table page allocated is zeroed by a sweep over the single table memory
// write port and then linked by one write. A rejected map returns its result
// without a walk. One item is worked on at a time; the next is taken once its
// result is queued. After reset the table memory is swept to zero, during
// which no item is accepted; configuration writes are taken throughout.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module sv39_page_table_walk_and_map_unit
	import sv39_ptw_pkg::*;
#(
	parameter int POOL_PAGES    = POOL_PAGES_DEF,
	parameter int VA_LIMIT_BITS = VA_LIMIT_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	// Item channel
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                kind,
	input  logic [63:0]         virt_addr,
	input  logic [55:0]         phys_addr,
	input  logic [38:0]         map_size,
	input  logic [9:0]          perm_bits,
	// Result channel
	output logic                out_valid,
	input  logic                out_stall,
	output logic [2:0]          status,
	output logic [63:0]         leaf_entry,
	// Configuration port
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [63:0]         pwdata,
	output logic [63:0]         prdata,
	output logic                pready
);

	localparam int PW    = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
	localparam int AW    = PW + IDX_BITS;
	localparam int DEPTH = POOL_PAGES * ENTRIES_PER_TABLE;
	localparam int FW    = $clog2(POOL_PAGES + 1);

	// Configuration register.
	logic [PPN_BITS-1:0] base_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= POOL_BASE_RESET;
		end else if (psel && penable && pwrite && paddr == REG_POOL_BASE) begin
			base_q <= pwdata[PPN_BITS-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == REG_POOL_BASE) begin
			prdata = {20'd0, base_q};
		end
	end

	// Table memory: one write port and one registered read port. When a read
	// and a write hit the same entry in one cycle, the new data is forwarded.
	logic [63:0]   mem [DEPTH];
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [63:0]   mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	logic [63:0]   mem_rdata_q;
	logic          fwd_q;
	logic [63:0]   fwd_data_q;
	logic [63:0]   rd_entry;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			mem_rdata_q <= mem[mem_raddr];
		end
	end

	always_ff @(posedge clk) begin
		fwd_q      <= mem_we && mem_re && (mem_waddr == mem_raddr);
		fwd_data_q <= mem_wdata;
	end

	assign rd_entry = fwd_q ? fwd_data_q : mem_rdata_q;

	// Walk state.
	walk_state_t           state_q, state_d;
	logic                  kind_q;
	logic [63:0]           va_q;
	logic [PPN_BITS-1:0]   ppn_q;
	logic [PAGES_BITS-1:0] pages_q;
	logic [9:0]            perm_q;
	logic [1:0]            level_q;
	logic [PW-1:0]         page_q;
	logic [FW-1:0]         next_free_q;
	logic [AW-1:0]         clr_cnt_q;
	logic [AW-1:0]         link_addr_q;
	status_t               res_status_q;
	logic [63:0]           res_leaf_q;
	logic                  out_valid_q;
	status_t               out_status_q;
	logic [63:0]           out_leaf_q;

	logic accept;
	logic out_free;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// Decode of the entry just read.
	logic                entry_v;
	logic [PPN_BITS-1:0] entry_off;
	logic                off_in_pool;
	logic                pool_full;
	logic                va_out_of_range;
	logic                in_misaligned;
	logic                in_zero;
	logic                clr_last;
	logic [1:0]          level_dn;

	always_comb begin
		entry_v         = rd_entry[0];
		entry_off       = rd_entry[10 +: PPN_BITS] - base_q;
		off_in_pool     = entry_off < PPN_BITS'(POOL_PAGES);
		pool_full       = next_free_q >= FW'(POOL_PAGES);
		va_out_of_range = (va_q >> VA_LIMIT_BITS) != 64'd0;
		in_misaligned   = (virt_addr[PAGE_SHIFT-1:0] != '0)
			|| (map_size[PAGE_SHIFT-1:0] != '0);
		in_zero         = (map_size == 39'd0);
		clr_last        = (clr_cnt_q == AW'(DEPTH - 1));
		level_dn        = level_q - 2'd1;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					if (kind == KIND_MAP && (in_misaligned || in_zero)) begin
						state_d = S_DONE;
					end else begin
						state_d = S_START;
					end
				end
			end
			S_START: begin
				state_d = va_out_of_range ? S_DONE : S_EVAL;
			end
			S_EVAL: begin
				if (level_q != 2'd0) begin
					if (entry_v) begin
						state_d = off_in_pool ? S_EVAL : S_DONE;
					end else if (kind_q == KIND_LOOKUP || pool_full) begin
						state_d = S_DONE;
					end else begin
						state_d = S_ZERO;
					end
				end else if (kind_q == KIND_LOOKUP || entry_v) begin
					state_d = S_DONE;
				end else begin
					state_d = (pages_q == PAGES_BITS'(1)) ? S_DONE : S_START;
				end
			end
			S_ZERO: begin
				if (clr_cnt_q[IDX_BITS-1:0] == '1) begin
					state_d = S_LINK;
				end
			end
			S_LINK: begin
				state_d = S_EVAL;
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_CLEAR;
		endcase
	end

	// Memory port controls.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = '0;
		unique case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_cnt_q;
			end
			S_START: begin
				mem_re    = !va_out_of_range;
				mem_raddr = {PW'(0), vpn_of(va_q, 2'd2)};
			end
			S_EVAL: begin
				if (level_q != 2'd0) begin
					mem_re    = entry_v && off_in_pool;
					mem_raddr = {entry_off[PW-1:0], vpn_of(va_q, level_dn)};
				end else if (kind_q == KIND_MAP && !entry_v) begin
					mem_we    = 1'b1;
					mem_waddr = {page_q, vpn_of(va_q, 2'd0)};
					mem_wdata = make_entry(ppn_q, perm_q | 10'd1);
				end
			end
			S_ZERO: begin
				mem_we    = 1'b1;
				mem_waddr = {page_q, clr_cnt_q[IDX_BITS-1:0]};
			end
			S_LINK: begin
				mem_we    = 1'b1;
				mem_waddr = link_addr_q;
				mem_wdata = make_entry(base_q + PPN_BITS'(page_q), 10'd1);
				mem_re    = 1'b1;
				mem_raddr = {page_q, vpn_of(va_q, level_q)};
			end
			default: begin
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_cnt_q   <= '0;
			next_free_q <= FW'(1);
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR || state_q == S_ZERO) begin
				clr_cnt_q <= clr_cnt_q + AW'(1);
			end else begin
				clr_cnt_q <= '0;
			end
			if (state_q == S_EVAL && level_q != 2'd0 && !entry_v
				&& kind_q == KIND_MAP && !pool_full) begin
				next_free_q <= next_free_q + FW'(1);
			end
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Item and walk registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q       <= kind;
			va_q         <= virt_addr;
			ppn_q        <= phys_addr[PAGE_SHIFT +: PPN_BITS];
			pages_q      <= map_size[38:PAGE_SHIFT];
			perm_q       <= perm_bits;
			res_leaf_q   <= '0;
			res_status_q <= in_misaligned ? ST_ALIGN : ST_ZERO;
		end
		unique case (state_q)
			S_START: begin
				page_q       <= '0;
				level_q      <= 2'd2;
				res_status_q <= ST_RANGE;
			end
			S_EVAL: begin
				if (level_q != 2'd0) begin
					res_status_q <= ST_NOPAGE;
					level_q      <= level_dn;
					if (entry_v) begin
						page_q <= entry_off[PW-1:0];
					end else begin
						link_addr_q <= {page_q, vpn_of(va_q, level_q)};
						page_q      <= next_free_q[PW-1:0];
					end
				end else if (kind_q == KIND_LOOKUP) begin
					res_status_q <= ST_OK;
					res_leaf_q   <= rd_entry;
				end else if (entry_v) begin
					res_status_q <= ST_REMAP;
				end else begin
					res_status_q <= ST_OK;
					pages_q      <= pages_q - PAGES_BITS'(1);
					va_q         <= va_q + 64'd4096;
					ppn_q        <= ppn_q + PPN_BITS'(1);
				end
			end
			default: begin
			end
		endcase
		if (state_q == S_DONE && out_free) begin
			out_status_q <= res_status_q;
			out_leaf_q   <= res_leaf_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = out_status_q;
	assign leaf_entry = out_leaf_q;

	`ASSERT_ALWAYS(a_free_bound, next_free_q <= FW'(POOL_PAGES), "free page count past pool size")
	`ASSERT_IMPLIES(a_leaf_zero, out_valid && status != ST_OK, leaf_entry == 64'd0, "leaf on failure")
	`ASSERT_IMPLIES(a_idle_no_write, state_q == S_IDLE, !mem_we, "table write while idle")
	`ASSERT_IMPLIES(a_clear_stall, state_q == S_CLEAR, in_stall, "item taken during clearing")

endmodule

// ----- dv/sv39_page_table_walk_and_map_unit_tb.sv -----
//------------------------------------------------------------------------------
// Sv39 page table walk and map unit testbench
// Drives lookups and range maps with bursty timing on both sides. A scoreboard
// keeps its own copy of the table pool and checks every result beat in order.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module sv39_page_table_walk_and_map_unit_tb;
	import sv39_ptw_pkg::*;

	localparam int          POOL     = POOL_PAGES_DEF;
	localparam int          VA_LIM   = VA_LIMIT_BITS_DEF;
	localparam logic [63:0] PG       = 64'd4096;
	localparam logic [63:0] VA_TOP   = 64'd1 << VA_LIM;
	localparam logic [3:0]  BASE_ADR = 4'(REG_POOL_BASE * 8);

	// Scoreboard: mirrors the table pool and the free page counter, and keeps
	// the expected result beats in arrival order.
	class pte_scoreboard;
		logic [63:0] tbl [POOL*ENTRIES_PER_TABLE];
		int unsigned free_pg;
		logic [43:0] base;
		status_t     want_status [$];
		logic [63:0] want_leaf [$];
		int          mismatches;

		function new();
			foreach (tbl[i]) tbl[i] = '0;
			free_pg = 1;
			base = POOL_BASE_RESET;
			mismatches = 0;
		endfunction

		function void set_pool_base(logic [43:0] v);
			base = v;
		endfunction

		function automatic int unsigned idx(logic [63:0] va, int lvl);
			return 32'((va >> (PAGE_SHIFT + 9 * lvl)) & 64'h1FF);
		endfunction

		// Walks the two upper levels; allocates missing tables when asked.
		function automatic status_t walk(logic [63:0] va, bit alloc, output int unsigned slot);
			int unsigned page, at;
			logic [43:0] off;
			page = 0;
			slot = 0;
			if (va >= VA_TOP) return ST_RANGE;
			for (int lvl = 2; lvl > 0; lvl--) begin
				at = page * ENTRIES_PER_TABLE + idx(va, lvl);
				if (tbl[at][0]) begin
					off = tbl[at][53:10] - base;
					if (off >= POOL) return ST_NOPAGE;
					page = 32'(off);
				end else begin
					if (!alloc || free_pg >= POOL) return ST_NOPAGE;
					page = free_pg++;
					for (int e = 0; e < ENTRIES_PER_TABLE; e++)
						tbl[page * ENTRIES_PER_TABLE + e] = '0;
					tbl[at] = make_entry(base + 44'(page), 10'd1);
				end
			end
			slot = page * ENTRIES_PER_TABLE + idx(va, 0);
			return ST_OK;
		endfunction

		function automatic status_t map_pages(logic [63:0] va, logic [55:0] pa,
			logic [38:0] size, logic [9:0] perm);
			logic [43:0] ppn;
			logic [26:0] n_pages;
			int unsigned slot;
			status_t st;
			ppn = pa[55:12];
			if (va[11:0] != 0 || size[11:0] != 0) return ST_ALIGN;
			if (size == 0) return ST_ZERO;
			n_pages = size[38:12];
			for (longint n = 0; n < n_pages; n++) begin
				st = walk(va, 1'b1, slot);
				if (st != ST_OK) return st;
				if (tbl[slot][0]) return ST_REMAP;
				tbl[slot] = make_entry(ppn, perm | 10'd1);
				va += PG;
				ppn += 44'd1;
			end
			return ST_OK;
		endfunction

		// Notes one accepted input beat and queues the result it must cause.
		function void note_item(logic k, logic [63:0] va, logic [55:0] pa,
			logic [38:0] size, logic [9:0] perm);
			int unsigned slot;
			status_t st;
			logic [63:0] leaf;
			leaf = '0;
			if (k == KIND_LOOKUP) begin
				st = walk(va, 1'b0, slot);
				if (st == ST_OK) leaf = tbl[slot];
			end else begin
				st = map_pages(va, pa, size, perm);
			end
			want_status.push_back(st);
			want_leaf.push_back(leaf);
		endfunction

		function void check_result(logic [2:0] st, logic [63:0] leaf);
			if (want_status.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result beat with nothing expected (status %0d leaf %h)",
						$time, st, leaf);
				return;
			end
			if (st !== want_status[0] || leaf !== want_leaf[0]) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: mismatch: status exp %0d got %0d, leaf exp %h got %h",
						$time, want_status[0], st, want_leaf[0], leaf);
			end
			void'(want_status.pop_front());
			void'(want_leaf.pop_front());
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid, in_stall;
	logic        kind;
	logic [63:0] virt_addr;
	logic [55:0] phys_addr;
	logic [38:0] map_size;
	logic [9:0]  perm_bits;
	logic        out_valid, out_stall;
	logic [2:0]  status;
	logic [63:0] leaf_entry;
	logic        psel, penable, pwrite, pready;
	logic [3:0]  paddr;
	logic [63:0] pwdata, prdata;

	pte_scoreboard sb = new();

	// Sender burst bookkeeping and the receiver's long hold-off request.
	int burst_left = 0;
	int hold_cycles = 0;

	sv39_page_table_walk_and_map_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .kind(kind),
		.virt_addr(virt_addr), .phys_addr(phys_addr), .map_size(map_size),
		.perm_bits(perm_bits),
		.out_valid(out_valid), .out_stall(out_stall), .status(status),
		.leaf_entry(leaf_entry),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Result side. Every accepted beat goes straight to the scoreboard.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(status, leaf_entry);
	end

	// The receiver stalls on a pattern whose mode is redrawn at random: no
	// stalls, light random stalls, alternating stalls, or heavy stalls. A long
	// hold-off, when requested, overrides the pattern so the block backs up.
	always begin : receiver
		int cyc;
		int rx_mode;
		cyc = 0;
		rx_mode = 0;
		forever begin
			@(negedge clk);
			if (cyc % 64 == 0) rx_mode = $urandom_range(0, 3);
			cyc++;
			if (hold_cycles > 0) begin
				out_stall <= 1'b1;
				hold_cycles--;
			end else begin
				case (rx_mode)
					0: begin
						out_stall <= 1'b0;
					end
					1: begin
						out_stall <= ($urandom_range(0, 9) < 3);
					end
					2: begin
						out_stall <= cyc[0];
					end
					default: begin
						out_stall <= ($urandom_range(0, 9) < 7);
					end
				endcase
			end
		end
	end

	// Offers one input beat and waits for it to be taken. Bursts of random
	// length are mostly separated by random gaps; valid stays high within a burst.
	task automatic push_item(input logic k, input logic [63:0] va, input logic [55:0] pa,
		input logic [38:0] size, input logic [9:0] perm);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		@(negedge clk);
		in_valid  <= 1'b1;
		kind      <= k;
		virt_addr <= va;
		phys_addr <= pa;
		map_size  <= size;
		perm_bits <= perm;
		do @(posedge clk); while (in_stall);
		sb.note_item(k, va, pa, size, perm);
		burst_left--;
	endtask

	// Drops valid and waits until every expected beat has come back, then
	// lets the block settle before a register write.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		burst_left = 0;
		while (sb.want_status.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// Register write with a setup and an access cycle, then a read back.
	task automatic write_pool_base(input logic [43:0] v);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= BASE_ADR;
		pwdata  <= {20'd0, v};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_pool_base(v);
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[43:0] !== v) begin
			sb.mismatches++;
			if (sb.mismatches <= 10)
				$display("%0t: pool base read back exp %h got %h", $time, v, prdata[43:0]);
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Virtual address inside a small set of regions so that tables are shared,
	// remaps happen and lookups hit. Now and then a fresh middle index is used,
	// which slowly uses up the pool.
	function automatic logic [63:0] region_va();
		logic [8:0] l2, l1;
		case ($urandom_range(0, 3))
			0: l2 = 9'd0;
			1: l2 = 9'd1;
			2: l2 = 9'd37;
			default: l2 = 9'd255;
		endcase
		if ($urandom_range(0, 9) == 0) l1 = 9'($urandom_range(0, 511));
		else l1 = 9'($urandom_range(0, 3) == 3 ? 511 : $urandom_range(0, 2));
		return {25'd0, l2, l1, 9'($urandom_range(0, 511)), 12'd0};
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic random_items(input int count);
		logic [63:0] va;
		logic [38:0] size;
		int pick;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				// Well-formed map; a few ranges are long.
				size = 39'($urandom_range(0, 19) == 0 ? $urandom_range(5, 32)
					: $urandom_range(1, 4)) << 12;
				push_item(KIND_MAP, region_va(), 56'(rand64()), size, 10'($urandom));
			end else if (pick < 85) begin
				va = region_va() | 64'($urandom_range(0, 4095));
				push_item(KIND_LOOKUP, va, 56'(rand64()), 39'(rand64()), 10'($urandom));
			end else begin
				// Noise over the full field ranges. An aligned map inside the
				// limit is kept misaligned so it cannot run for ages.
				va = rand64();
				if ($urandom_range(0, 1)) va[11:0] = 12'd0;
				size = 39'(rand64());
				if (va < VA_TOP) size[0] = 1'b1;
				push_item(1'($urandom), va, 56'(rand64()), size, 10'($urandom));
			end
		end
	endtask

	initial begin
		in_valid  = 1'b0;
		kind      = KIND_LOOKUP;
		virt_addr = '0;
		phys_addr = '0;
		map_size  = '0;
		perm_bits = '0;
		out_stall = 1'b0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		arst_n    = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		write_pool_base(POOL_BASE_RESET);

		// Directed part: empty tables, out of range, alignment and zero size,
		// widest physical page with wrap, remap after partial progress, and a
		// maximal size that stops at the limit.
		push_item(KIND_LOOKUP, 64'h0, '0, '0, '0);
		push_item(KIND_LOOKUP, VA_TOP, '0, '0, '0);
		push_item(KIND_LOOKUP, '1, '1, '1, '1);
		push_item(KIND_MAP, 64'h1001, '0, 39'h1000, '0);
		push_item(KIND_MAP, 64'h1000, '0, 39'h800, '0);
		push_item(KIND_MAP, 64'h1000, '0, 39'h0, '0);
		push_item(KIND_MAP, 64'h0, '1, 39'h1000, 10'h3FF);
		push_item(KIND_LOOKUP, 64'h0, '0, '0, '0);
		push_item(KIND_MAP, 64'h0, '0, 39'h1000, 10'h0);
		push_item(KIND_MAP, VA_TOP - PG, '1, 39'h40_0000_0000, 10'h2AA);
		push_item(KIND_LOOKUP, VA_TOP - 64'd1, '0, '0, '0);
		push_item(KIND_MAP, VA_TOP, '0, 39'h1000, '0);
		push_item(KIND_MAP, 64'h2000, 56'hFF_FFFF_FFFF_F000, 39'h3000, 10'h000);
		push_item(KIND_LOOKUP, 64'h2000, '0, '0, '0);
		push_item(KIND_LOOKUP, 64'h3FFF, '0, '0, '0);
		push_item(KIND_LOOKUP, 64'h4000, '0, '0, '0);
		push_item(KIND_MAP, 64'h1000, 56'h1234_5000, 39'h3000, 10'h155);
		push_item(KIND_LOOKUP, 64'h1000, '0, '0, '0);
		push_item(KIND_LOOKUP, 64'h4000_0000, '0, '0, '0);
		push_item(KIND_LOOKUP, 64'h20_0000, '0, '0, '0);
		push_item(KIND_MAP, 64'h7F_FFFF_F000, 56'h5000, 39'h2000, 10'h0F0);

		// Hold the receiver off for a long stretch while items keep coming.
		hold_cycles = 400;
		random_items(1100);
		drain();

		// With the base moved, earlier table pointers fall outside the pool.
		write_pool_base(44'd0);
		random_items(150);
		drain();
		write_pool_base(44'hFFF_FFFF_FFFF);
		random_items(150);
		drain();
		write_pool_base(POOL_BASE_RESET);
		random_items(150);
		drain();

		if (sb.mismatches == 0 && sb.want_status.size() == 0) begin
			$display("sv39_page_table_walk_and_map_unit_tb: done, clean");
		end else begin
			$display("sv39_page_table_walk_and_map_unit_tb: done, errors");
		end
		$finish;
	end

	// Covers the reset sweep, every table page allocation and the stalls with
	// a wide margin.
	initial begin
		#20ms;
		$display("sv39_page_table_walk_and_map_unit_tb: done, errors");
		$finish;
	end

endmodule

// ----- sv39_page_table_walk_and_map_unit.f -----
+incdir+design
design/sv39_ptw_pkg.sv
design/sv39_page_table_walk_and_map_unit.sv
dv/sv39_page_table_walk_and_map_unit_tb.sv
